/* rtl/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants and types for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // default datapath sizes
  localparam int COORD_WIDTH     = 32;
  localparam int PARAM_FRAC_BITS = 16;

  // control points per request and highest supported degree
  localparam int CTRL_PTS   = 4;
  localparam int DEGREE_MAX = CTRL_PTS - 1;

  // degree selector codes (any other code evaluates as cubic)
  localparam logic [1:0] FUNC_LINEAR = 2'd0;
  localparam logic [1:0] FUNC_QUAD   = 2'd1;
  localparam logic [1:0] FUNC_CUBIC  = 2'd2;

  localparam int LIFT_W = 2;

  // per-stage control that travels with the data
  typedef struct packed {
    logic              valid;
    logic [LIFT_W-1:0] lift;   // leading levels that only scale by 1.0
  } pipe_ctl_t;

endpackage

/* rtl/bpe_if.sv */
// ----------------------------------------------------------------------------
// bpe_if
// Request and response channels of the Bezier point evaluator.
// ----------------------------------------------------------------------------
interface bpe_req_if #(
  parameter int COORD_WIDTH     = bpe_pkg::COORD_WIDTH,
  parameter int PARAM_FRAC_BITS = bpe_pkg::PARAM_FRAC_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [PARAM_FRAC_BITS:0]      param_t;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;

  modport source (
    output valid, func, param_t, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );
  modport sink (
    input  valid, func, param_t, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

interface bpe_rsp_if #(
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] curve_x;
  logic signed [COORD_WIDTH-1:0] curve_y;

  modport source (output valid, curve_x, curve_y, input ready);
  modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

/* rtl/bpe_capture.sv */
// ----------------------------------------------------------------------------
// bpe_capture
// Input stage: clamps t, forms u = 1 - t, picks the number of scale-only
// levels from the degree and moves the coordinates to offset binary.
// ----------------------------------------------------------------------------
module bpe_capture #(
  parameter int COORD_WIDTH     = bpe_pkg::COORD_WIDTH,
  parameter int PARAM_FRAC_BITS = bpe_pkg::PARAM_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [1:0]               func_i,
  input  logic [PARAM_FRAC_BITS:0] param_t_i,
  input  logic [COORD_WIDTH-1:0]   x_i [bpe_pkg::CTRL_PTS],
  input  logic [COORD_WIDTH-1:0]   y_i [bpe_pkg::CTRL_PTS],
  output bpe_pkg::pipe_ctl_t       ctl_o,
  input  logic                     ready_i,
  output logic [PARAM_FRAC_BITS:0] t_o,
  output logic [PARAM_FRAC_BITS:0] u_o,
  output logic [COORD_WIDTH-1:0]   x_o [bpe_pkg::CTRL_PTS],
  output logic [COORD_WIDTH-1:0]   y_o [bpe_pkg::CTRL_PTS]
);

  localparam logic [PARAM_FRAC_BITS:0] T_ONE = (PARAM_FRAC_BITS+1)'(1) << PARAM_FRAC_BITS;

  bpe_pkg::pipe_ctl_t ctl_d, ctl_q;
  logic [PARAM_FRAC_BITS:0] t_d, t_q, u_d, u_q;
  logic [COORD_WIDTH-1:0]   x_d [bpe_pkg::CTRL_PTS];
  logic [COORD_WIDTH-1:0]   y_d [bpe_pkg::CTRL_PTS];
  logic [COORD_WIDTH-1:0]   x_q [bpe_pkg::CTRL_PTS];
  logic [COORD_WIDTH-1:0]   y_q [bpe_pkg::CTRL_PTS];
  logic                     load;

  assign ready_o = !ctl_q.valid || ready_i;
  assign load    = ready_o && valid_i;

  always_comb begin
    ctl_d.valid = valid_i;
    unique case (func_i)
      bpe_pkg::FUNC_LINEAR: ctl_d.lift = bpe_pkg::LIFT_W'(2);
      bpe_pkg::FUNC_QUAD:   ctl_d.lift = bpe_pkg::LIFT_W'(1);
      default:              ctl_d.lift = '0;
    endcase
    t_d = (param_t_i > T_ONE) ? T_ONE : param_t_i;
    u_d = T_ONE - t_d;
  end

  // sign flip turns two's complement into offset binary
  for (genvar i = 0; i < bpe_pkg::CTRL_PTS; i++) begin : g_pt
    assign x_d[i] = {~x_i[i][COORD_WIDTH-1], x_i[i][COORD_WIDTH-2:0]};
    assign y_d[i] = {~y_i[i][COORD_WIDTH-1], y_i[i][COORD_WIDTH-2:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      t_q <= t_d;
      u_q <= u_d;
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign ctl_o = ctl_q;
  assign t_o   = t_q;
  assign u_o   = u_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

  a_weights_sum_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.valid |-> ({1'b0, t_q} + {1'b0, u_q}) == {1'b0, T_ONE})
    else $error("t and u do not sum to one");

  a_lift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.valid |-> ctl_q.lift < bpe_pkg::LIFT_W'(bpe_pkg::DEGREE_MAX))
    else $error("scale-only level count out of range");

endmodule

/* rtl/bpe_level.sv */
// ----------------------------------------------------------------------------
// bpe_level
// One de Casteljau level, kept exact: out[i] = u*a[i] + t*a[i+1], which grows
// by PARAM_FRAC_BITS. Lower-degree requests skip the leading levels by
// scaling a[i] by 1.0 instead, so every degree leaves with the same scale.
// ----------------------------------------------------------------------------
module bpe_level #(
  parameter int PARAM_FRAC_BITS = bpe_pkg::PARAM_FRAC_BITS,
  parameter int IN_W            = bpe_pkg::COORD_WIDTH,
  parameter int NUM_IN          = bpe_pkg::CTRL_PTS,
  parameter int LEVEL           = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpe_pkg::pipe_ctl_t                  ctl_i,
  output logic                                ready_o,
  input  logic [PARAM_FRAC_BITS:0]            t_i,
  input  logic [PARAM_FRAC_BITS:0]            u_i,
  input  logic [IN_W-1:0]                     x_i [NUM_IN],
  input  logic [IN_W-1:0]                     y_i [NUM_IN],
  output bpe_pkg::pipe_ctl_t                  ctl_o,
  input  logic                                ready_i,
  output logic [PARAM_FRAC_BITS:0]            t_o,
  output logic [PARAM_FRAC_BITS:0]            u_o,
  output logic [IN_W+PARAM_FRAC_BITS-1:0]     x_o [NUM_IN-1],
  output logic [IN_W+PARAM_FRAC_BITS-1:0]     y_o [NUM_IN-1]
);

  localparam int NUM_OUT = NUM_IN - 1;
  localparam int OUT_W   = IN_W + PARAM_FRAC_BITS;
  localparam int PROD_W  = OUT_W + 1;

  bpe_pkg::pipe_ctl_t       ctl_q;
  logic [PARAM_FRAC_BITS:0] t_q, u_q;
  logic [OUT_W-1:0]         x_d [NUM_OUT];
  logic [OUT_W-1:0]         y_d [NUM_OUT];
  logic [OUT_W-1:0]         x_q [NUM_OUT];
  logic [OUT_W-1:0]         y_q [NUM_OUT];
  logic                     load;
  logic                     scale_only;

  assign ready_o    = !ctl_q.valid || ready_i;
  assign load       = ready_o && ctl_i.valid;
  assign scale_only = ctl_i.lift >= bpe_pkg::LIFT_W'(LEVEL);

  for (genvar i = 0; i < NUM_OUT; i++) begin : g_lane
    logic [PROD_W-1:0] mix_x, mix_y;

    assign mix_x = PROD_W'(u_i) * PROD_W'(x_i[i]) + PROD_W'(t_i) * PROD_W'(x_i[i+1]);
    assign mix_y = PROD_W'(u_i) * PROD_W'(y_i[i]) + PROD_W'(t_i) * PROD_W'(y_i[i+1]);

    // convex mix stays below 2^OUT_W, top bit of the sum is always clear
    assign x_d[i] = scale_only ? {x_i[i], {PARAM_FRAC_BITS{1'b0}}} : mix_x[OUT_W-1:0];
    assign y_d[i] = scale_only ? {y_i[i], {PARAM_FRAC_BITS{1'b0}}} : mix_y[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      t_q <= t_i;
      u_q <= u_i;
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign ctl_o = ctl_q;
  assign t_o   = t_q;
  assign u_o   = u_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

  a_scale_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && scale_only |=> x_q[0] == {$past(x_i[0]), {PARAM_FRAC_BITS{1'b0}}})
    else $error("skipped level did not scale its point by one");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.valid && !ready_i |=> ctl_q.valid && $stable(x_q[0]) && $stable(y_q[0]))
    else $error("stalled level lost or changed its item");

endmodule

/* rtl/bpe_round.sv */
// ----------------------------------------------------------------------------
// bpe_round
// Output stage: rounds the exact sum to nearest (halves up), drops the
// fraction growth of all three levels and returns to two's complement.
// ----------------------------------------------------------------------------
module bpe_round #(
  parameter int COORD_WIDTH     = bpe_pkg::COORD_WIDTH,
  parameter int PARAM_FRAC_BITS = bpe_pkg::PARAM_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpe_pkg::pipe_ctl_t     ctl_i,
  output logic                   ready_o,
  input  logic [COORD_WIDTH+bpe_pkg::DEGREE_MAX*PARAM_FRAC_BITS-1:0] x_i,
  input  logic [COORD_WIDTH+bpe_pkg::DEGREE_MAX*PARAM_FRAC_BITS-1:0] y_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [COORD_WIDTH-1:0] curve_x_o,
  output logic [COORD_WIDTH-1:0] curve_y_o
);

  localparam int SHIFT = bpe_pkg::DEGREE_MAX * PARAM_FRAC_BITS;
  localparam int ACC_W = COORD_WIDTH + SHIFT;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SHIFT - 1);

  logic                   valid_q;
  logic [ACC_W-1:0]       sum_x, sum_y;
  logic [COORD_WIDTH-1:0] x_d, y_d, x_q, y_q;

  assign ready_o = !valid_q || ready_i;

  // the sum stays below 2^ACC_W even with the half added
  assign sum_x = x_i + HALF;
  assign sum_y = y_i + HALF;
  assign x_d   = {~sum_x[ACC_W-1], sum_x[ACC_W-2:SHIFT]};
  assign y_d   = {~sum_y[ACC_W-1], sum_y[ACC_W-2:SHIFT]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign valid_o   = valid_q;
  assign curve_x_o = x_q;
  assign curve_y_o = y_q;

endmodule

/* rtl/bezier_point_evaluator.sv */
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// Linear, quadratic or cubic Bezier point at t, exact and rounded once.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the response stalls; it has an input
// register, three de Casteljau levels (u*a + t*b, kept exact, one level per
// stage with a multiplier pair per lane and coordinate) and a rounding output
// register. Linear and quadratic requests run the same five stages; their
// first one or two levels only scale by 1.0. Results leave in request order,
// and a stalled response backs up the pipe without dropping anything.
// ----------------------------------------------------------------------------
module bezier_point_evaluator #(
  parameter int COORD_WIDTH     = bpe_pkg::COORD_WIDTH,
  parameter int PARAM_FRAC_BITS = bpe_pkg::PARAM_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpe_req_if.sink   req_i,
  bpe_rsp_if.source rsp_o
);

  localparam int NP  = bpe_pkg::CTRL_PTS;
  localparam int F   = PARAM_FRAC_BITS;
  localparam int W1  = COORD_WIDTH + F;
  localparam int W2  = COORD_WIDTH + 2 * F;
  localparam int W3  = COORD_WIDTH + 3 * F;

  logic [COORD_WIDTH-1:0] in_x [NP];
  logic [COORD_WIDTH-1:0] in_y [NP];
  logic [COORD_WIDTH-1:0] s0_x [NP];
  logic [COORD_WIDTH-1:0] s0_y [NP];
  logic [W1-1:0]          s1_x [NP-1];
  logic [W1-1:0]          s1_y [NP-1];
  logic [W2-1:0]          s2_x [NP-2];
  logic [W2-1:0]          s2_y [NP-2];
  logic [W3-1:0]          s3_x [NP-3];
  logic [W3-1:0]          s3_y [NP-3];

  logic [F:0] s0_t, s0_u, s1_t, s1_u, s2_t, s2_u;

  bpe_pkg::pipe_ctl_t s0_ctl, s1_ctl, s2_ctl, s3_ctl;
  logic s0_rdy, s1_rdy, s2_rdy, s3_rdy;

  assign in_x[0] = req_i.p0_x;
  assign in_x[1] = req_i.p1_x;
  assign in_x[2] = req_i.p2_x;
  assign in_x[3] = req_i.p3_x;
  assign in_y[0] = req_i.p0_y;
  assign in_y[1] = req_i.p1_y;
  assign in_y[2] = req_i.p2_y;
  assign in_y[3] = req_i.p3_y;

  bpe_capture #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req_i.valid),
    .ready_o  (req_i.ready),
    .func_i   (req_i.func),
    .param_t_i(req_i.param_t),
    .x_i      (in_x),
    .y_i      (in_y),
    .ctl_o    (s0_ctl),
    .ready_i  (s0_rdy),
    .t_o      (s0_t),
    .u_o      (s0_u),
    .x_o      (s0_x),
    .y_o      (s0_y)
  );

  bpe_level #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
    .IN_W           (COORD_WIDTH),
    .NUM_IN         (NP),
    .LEVEL          (1)
  ) u_level1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s0_ctl),
    .ready_o(s0_rdy),
    .t_i    (s0_t),
    .u_i    (s0_u),
    .x_i    (s0_x),
    .y_i    (s0_y),
    .ctl_o  (s1_ctl),
    .ready_i(s1_rdy),
    .t_o    (s1_t),
    .u_o    (s1_u),
    .x_o    (s1_x),
    .y_o    (s1_y)
  );

  bpe_level #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
    .IN_W           (W1),
    .NUM_IN         (NP - 1),
    .LEVEL          (2)
  ) u_level2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s1_ctl),
    .ready_o(s1_rdy),
    .t_i    (s1_t),
    .u_i    (s1_u),
    .x_i    (s1_x),
    .y_i    (s1_y),
    .ctl_o  (s2_ctl),
    .ready_i(s2_rdy),
    .t_o    (s2_t),
    .u_o    (s2_u),
    .x_o    (s2_x),
    .y_o    (s2_y)
  );

  // last level: t and u are not needed past this point
  bpe_level #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
    .IN_W           (W2),
    .NUM_IN         (NP - 2),
    .LEVEL          (3)
  ) u_level3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s2_ctl),
    .ready_o(s2_rdy),
    .t_i    (s2_t),
    .u_i    (s2_u),
    .x_i    (s2_x),
    .y_i    (s2_y),
    .ctl_o  (s3_ctl),
    .ready_i(s3_rdy),
    .t_o    (),
    .u_o    (),
    .x_o    (s3_x),
    .y_o    (s3_y)
  );

  bpe_round #(
    .COORD_WIDTH    (COORD_WIDTH),
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s3_ctl),
    .ready_o  (s3_rdy),
    .x_i      (s3_x[0]),
    .y_i      (s3_y[0]),
    .valid_o  (rsp_o.valid),
    .ready_i  (rsp_o.ready),
    .curve_x_o(rsp_o.curve_x),
    .curve_y_o(rsp_o.curve_y)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Bezier point evaluator against a bit-exact point predictor.
// Directed corner requests come first (extreme coordinates, t at 0, 1.0 and
// above, half-ulp rounding, every degree code), then random requests. Both
// handshakes stall at random in the first two of three phases but never in
// the third. Every response is compared in order with its predicted point.
// ----------------------------------------------------------------------------

localparam int COORD_WIDTH     = bpe_pkg::COORD_WIDTH;
localparam int PARAM_FRAC_BITS = bpe_pkg::PARAM_FRAC_BITS;
localparam int CTRL_PTS        = bpe_pkg::CTRL_PTS;
localparam int DEGREE_MAX      = bpe_pkg::DEGREE_MAX;

// exact Bernstein sums need coordinate + binomial + three t factors
localparam int ACC_W = COORD_WIDTH + 2 + DEGREE_MAX * (PARAM_FRAC_BITS + 1);
localparam int T_ONE = 1 << PARAM_FRAC_BITS;
localparam int T_W   = PARAM_FRAC_BITS + 1;

localparam logic [1:0] FUNC_CUBIC_ALIAS = 2'd3;  // spare code, evaluates as cubic

localparam logic [COORD_WIDTH-1:0] SIGN_FLIP  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
localparam logic [COORD_WIDTH-1:0] COORD_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
localparam logic [COORD_WIDTH-1:0] COORD_MIN  = SIGN_FLIP;
localparam logic [COORD_WIDTH-1:0] COORD_ULP  = COORD_WIDTH'(1);
localparam logic [PARAM_FRAC_BITS:0] T_ALL_ONES   = '1;
localparam logic [PARAM_FRAC_BITS:0] T_FULL       = T_W'(T_ONE);
localparam logic [PARAM_FRAC_BITS:0] T_HALF       = T_W'(T_ONE / 2);
localparam logic [PARAM_FRAC_BITS:0] T_THIRD      = T_W'(T_ONE / 3);
localparam logic [PARAM_FRAC_BITS:0] T_TWO_THIRDS = T_W'((T_ONE * 2) / 3);
localparam logic [PARAM_FRAC_BITS:0] T_ULP        = T_W'(1);
localparam logic [PARAM_FRAC_BITS:0] T_NEAR_ONE   = T_W'(T_ONE - 1);
localparam logic [PARAM_FRAC_BITS:0] T_PAST_ONE   = T_W'(T_ONE + 1);

typedef struct packed {
  logic [1:0]                           func;
  logic [PARAM_FRAC_BITS:0]             param_t;
  logic [CTRL_PTS-1:0][COORD_WIDTH-1:0] px;
  logic [CTRL_PTS-1:0][COORD_WIDTH-1:0] py;
} bezier_req_t;

typedef struct packed {
  logic [COORD_WIDTH-1:0] x;
  logic [COORD_WIDTH-1:0] y;
} curve_point_t;

class bezier_scoreboard;
  curve_point_t expected_q[$];
  int unsigned  mismatches;

  function void log_mismatch(string what, logic [COORD_WIDTH-1:0] want,
                             logic [COORD_WIDTH-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch %s: expected %h, got %h", $realtime, what, want, got);
    end
  endfunction

  // Sum is formed on offset-binary coordinates so it stays unsigned;
  // rounding half up there is rounding half up on the signed value too.
  function logic [COORD_WIDTH-1:0] blend_coord(int unsigned degree,
      logic [CTRL_PTS-1:0][COORD_WIDTH-1:0] pts,
      logic [ACC_W-1:0] tq, logic [ACC_W-1:0] uq);
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] term;
    int unsigned      k;
    int unsigned      j;
    int unsigned      shift;
    acc = '0;
    for (k = 0; k <= degree; k++) begin
      term = '0;
      term[COORD_WIDTH-1:0] = pts[k] ^ SIGN_FLIP;
      // inner binomial coefficients equal the degree for n <= 3
      if (k != 0 && k != degree) begin
        term = term * ACC_W'(degree);
      end
      for (j = 0; j < degree - k; j++) term = term * uq;
      for (j = 0; j < k; j++) term = term * tq;
      acc = acc + term;
    end
    shift = degree * PARAM_FRAC_BITS;
    acc = acc + (ACC_W'(1) << (shift - 1));
    acc = acc >> shift;
    return acc[COORD_WIDTH-1:0] ^ SIGN_FLIP;
  endfunction

  function void note_request(bezier_req_t r);
    int unsigned      degree;
    logic [ACC_W-1:0] tq;
    logic [ACC_W-1:0] uq;
    curve_point_t     pt;
    if (r.func == bpe_pkg::FUNC_LINEAR) degree = 1;
    else if (r.func == bpe_pkg::FUNC_QUAD) degree = 2;
    else degree = 3;
    tq = '0;
    tq[PARAM_FRAC_BITS:0] = r.param_t;
    if (tq > ACC_W'(T_ONE)) tq = ACC_W'(T_ONE);
    uq = ACC_W'(T_ONE) - tq;
    pt.x = blend_coord(degree, r.px, tq, uq);
    pt.y = blend_coord(degree, r.py, tq, uq);
    expected_q.insert(expected_q.size(), pt);
  endfunction

  function void check_response(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
    curve_point_t want;
    if (expected_q.size() == 0) begin
      log_mismatch("unexpected response x", '0, x);
    end else begin
      want = expected_q.pop_front();
      if (x !== want.x) log_mismatch("curve_x", want.x, x);
      if (y !== want.y) log_mismatch("curve_y", want.y, y);
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module testbench;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  bezier_scoreboard board;

  bpe_req_if req_bus ();
  bpe_rsp_if rsp_bus ();

  bezier_point_evaluator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bezier_req_t pack_request(logic [1:0] func,
      logic [PARAM_FRAC_BITS:0] param_t,
      logic [COORD_WIDTH-1:0] p0x, logic [COORD_WIDTH-1:0] p0y,
      logic [COORD_WIDTH-1:0] p1x, logic [COORD_WIDTH-1:0] p1y,
      logic [COORD_WIDTH-1:0] p2x, logic [COORD_WIDTH-1:0] p2y,
      logic [COORD_WIDTH-1:0] p3x, logic [COORD_WIDTH-1:0] p3y);
    bezier_req_t r;
    r.func    = func;
    r.param_t = param_t;
    r.px      = {p3x, p2x, p1x, p0x};
    r.py      = {p3y, p2y, p1y, p0y};
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    logic [COORD_WIDTH-1:0] c;
    case ($urandom_range(0, 9))
      0: c = COORD_MAX;
      1: c = COORD_MIN;
      2: c = COORD_WIDTH'($urandom_range(0, 1 << 20));
      3: c = -COORD_WIDTH'($urandom_range(0, 1 << 20));
      default: c = COORD_WIDTH'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [PARAM_FRAC_BITS:0] rand_param();
    logic [PARAM_FRAC_BITS:0] t;
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = T_FULL;
      2: t = T_W'($urandom_range(T_ONE + 1, 2 * T_ONE - 1));
      3: t = T_W'($urandom_range(1, 15));
      4: t = T_W'(T_ONE - $urandom_range(1, 15));
      default: t = T_W'($urandom_range(0, T_ONE));
    endcase
    return t;
  endfunction

  function automatic bezier_req_t rand_request();
    bezier_req_t r;
    int unsigned k;
    r.func    = 2'($urandom_range(0, 3));
    r.param_t = rand_param();
    for (k = 0; k < CTRL_PTS; k++) begin
      r.px[k] = rand_coord();
      r.py[k] = rand_coord();
    end
    return r;
  endfunction

  task automatic drive_request(bezier_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.func    <= r.func;
    req_bus.param_t <= r.param_t;
    req_bus.p0_x    <= r.px[0];
    req_bus.p0_y    <= r.py[0];
    req_bus.p1_x    <= r.px[1];
    req_bus.p1_y    <= r.py[1];
    req_bus.p2_x    <= r.px[2];
    req_bus.p2_y    <= r.py[2];
    req_bus.p3_x    <= r.px[3];
    req_bus.p3_y    <= r.py[3];
    do @(posedge clk); while (!req_bus.ready);
    board.note_request(r);
  endtask

  // hold the request side until every outstanding point has come back
  task automatic drain_points();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      board.check_response(rsp_bus.curve_x, rsp_bus.curve_y);
    end
    rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    board = new;
    send_idle_pct = 10;
    recv_idle_pct = 66;
    rst_n           <= 1'b0;
    req_bus.valid   <= 1'b0;
    req_bus.func    <= bpe_pkg::FUNC_LINEAR;
    req_bus.param_t <= '0;
    req_bus.p0_x    <= '0;
    req_bus.p0_y    <= '0;
    req_bus.p1_x    <= '0;
    req_bus.p1_y    <= '0;
    req_bus.p2_x    <= '0;
    req_bus.p2_y    <= '0;
    req_bus.p3_x    <= '0;
    req_bus.p3_y    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // linear: endpoints, midpoint, smallest steps away from both ends
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, '0, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX, '1, '1, '1, '1));
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, T_FULL, COORD_MAX, COORD_MIN,
                               COORD_MIN, COORD_MAX, '0, '1, '0, '1));
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, T_HALF, COORD_MAX, COORD_MIN,
                               COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                               COORD_MIN));
    // half-ulp ties: +0.5 ulp rounds up to 1, -0.5 ulp rounds up to 0
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, T_HALF, '0, '0, COORD_ULP, '1,
                               '0, '0, '0, '0));
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, T_ULP, COORD_MIN, COORD_MAX,
                               COORD_MAX, COORD_MIN, '0, '0, '0, '0));
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, T_NEAR_ONE, COORD_MIN, COORD_MAX,
                               COORD_MAX, COORD_MIN, '0, '0, '0, '0));
    // quadratic
    drive_request(pack_request(bpe_pkg::FUNC_QUAD, '0, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MAX, COORD_MIN, '1, '1));
    drive_request(pack_request(bpe_pkg::FUNC_QUAD, T_FULL, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MIN, COORD_MAX, '1, '1));
    drive_request(pack_request(bpe_pkg::FUNC_QUAD, T_HALF, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MAX, COORD_MIN, '0, '0));
    drive_request(pack_request(bpe_pkg::FUNC_QUAD, T_ULP, COORD_MIN, COORD_MIN, COORD_MAX,
                               COORD_MAX, COORD_MIN, COORD_MIN, '0, '0));
    // cubic
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, '0, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, T_FULL, COORD_MAX, COORD_MIN,
                               COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX));
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, T_HALF, COORD_MAX, COORD_MIN,
                               COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MAX));
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, T_NEAR_ONE, COORD_MIN, COORD_MAX,
                               COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                               COORD_MIN));
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, T_ULP, '0, '0, '0, '0, '0, '0,
                               COORD_ULP, '1));
    // spare selector code behaves as cubic
    drive_request(pack_request(FUNC_CUBIC_ALIAS, T_THIRD, rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord()));
    drive_request(pack_request(FUNC_CUBIC_ALIAS, T_ALL_ONES, COORD_MAX, COORD_MIN, '0, '0,
                               '1, '1, COORD_MIN, COORD_MAX));
    // t past 1.0 clamps to the last control point
    drive_request(pack_request(bpe_pkg::FUNC_LINEAR, T_PAST_ONE, COORD_MAX, COORD_MIN,
                               COORD_ULP, '1, COORD_MAX, COORD_MIN, '0, '0));
    drive_request(pack_request(bpe_pkg::FUNC_QUAD, T_ALL_ONES, '0, '0, '1, COORD_ULP,
                               COORD_MIN, COORD_MAX, '1, '1));
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, T_ALL_ONES, '0, '0, '0, '0, '0, '0,
                               COORD_MIN, COORD_MAX));
    // flat curves stay on the extreme value
    drive_request(pack_request(bpe_pkg::FUNC_CUBIC, T_THIRD, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX));
    drive_request(pack_request(bpe_pkg::FUNC_QUAD, T_TWO_THIRDS, COORD_MIN, COORD_MIN,
                               COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, '1, '1));
    drain_points();

    for (int i = 0; i < 550; i++) begin
      if (i == 183) begin
        drain_points();
        send_idle_pct = 66;
        recv_idle_pct = 10;
      end else if (i == 366) begin
        drain_points();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drive_request(rand_request());
    end

    req_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (12) @(posedge clk);
    if (board.pending() != 0) begin
      board.log_mismatch("points never returned", '0, COORD_WIDTH'(board.pending()));
    end
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
